/* sv/iso8601_utc_timestamp_checker_assert.svh */
// ----------------------------------------------------------------------------
// ISO 8601 timestamp checker assertion macros
// Concurrent assertion forms for the checker's assertion file.
// ----------------------------------------------------------------------------
`ifndef ISO8601_UTC_TIMESTAMP_CHECKER_ASSERT_SVH
`define ISO8601_UTC_TIMESTAMP_CHECKER_ASSERT_SVH

// same-cycle implication
`define ISOTS_ASSERT_IMPL(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("isots assertion failed (same cycle)");

// next-cycle implication
`define ISOTS_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("isots assertion failed (next cycle)");

`endif

/* sv/isots_pkg.sv */
// ----------------------------------------------------------------------------
// isots_pkg
// Types, character codes and field tables for the ISO 8601 UTC checker.
// ----------------------------------------------------------------------------
package isots_pkg;

  localparam int unsigned TS_LEN = 20;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] SEP_NONE = 8'h00;

  localparam logic [4:0] POS_LAST = 5'(TS_LEN - 1);
  localparam logic [4:0] POS_SAT  = 5'(TS_LEN);

  // field targeted by a digit position
  localparam logic [2:0] FLD_YEAR_HI = 3'd0;
  localparam logic [2:0] FLD_YEAR_LO = 3'd1;
  localparam logic [2:0] FLD_MONTH   = 3'd2;
  localparam logic [2:0] FLD_DAY     = 3'd3;
  localparam logic [2:0] FLD_HOUR    = 3'd4;
  localparam logic [2:0] FLD_MINUTE  = 3'd5;
  localparam logic [2:0] FLD_SECOND  = 3'd6;
  localparam logic [2:0] FLD_NONE    = 3'd7;

  localparam logic [6:0] MAX_MONTH  = 7'd12;
  localparam logic [6:0] MAX_HOUR   = 7'd23;
  localparam logic [6:0] MAX_MINSEC = 7'd59;

  localparam logic [4:0] MONTH_LEN [13] = '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31,
                                            5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30,
                                            5'd31};

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } item_t;

  function automatic logic [7:0] expected_sep(logic [4:0] pos);
    logic [7:0] s;
    case (pos)
      5'd4, 5'd7:   s = CH_DASH;
      5'd10:        s = CH_T;
      5'd13, 5'd16: s = CH_COLON;
      5'd19:        s = CH_Z;
      default:      s = SEP_NONE;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] field_of(logic [4:0] pos);
    logic [2:0] f;
    case (pos)
      5'd0, 5'd1:   f = FLD_YEAR_HI;
      5'd2, 5'd3:   f = FLD_YEAR_LO;
      5'd5, 5'd6:   f = FLD_MONTH;
      5'd8, 5'd9:   f = FLD_DAY;
      5'd11, 5'd12: f = FLD_HOUR;
      5'd14, 5'd15: f = FLD_MINUTE;
      5'd17, 5'd18: f = FLD_SECOND;
      default:      f = FLD_NONE;
    endcase
    return f;
  endfunction

  function automatic logic [6:0] acc10(logic [6:0] v, logic [3:0] d);
    logic [9:0] s;
    s = {v, 3'b000} + {2'b00, v, 1'b0} + {6'd0, d};
    return s[6:0];
  endfunction

endpackage

/* sv/isots_core.sv */
// ----------------------------------------------------------------------------
// isots_core
// Position tracking, field accumulation and verdict for one request per step.
// ----------------------------------------------------------------------------
module isots_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  isots_pkg::item_t item,
  output logic            ok
);
  import isots_pkg::*;

  logic [4:0] position, position_next;
  logic       mismatch, mismatch_next;
  logic [6:0] year_hi, year_hi_next;
  logic [6:0] year_lo, year_lo_next;
  logic [6:0] month, month_next;
  logic [6:0] day, day_next;
  logic [6:0] hour, hour_next;
  logic [6:0] minute, minute_next;
  logic [6:0] second, second_next;

  logic [7:0] sep;
  logic       is_digit;
  logic [3:0] digit;
  logic       leap;
  logic [4:0] days;
  logic       range_ok;

  assign sep      = expected_sep(position);
  assign is_digit = (item.char_code >= CH_ZERO) && (item.char_code <= CH_NINE);
  assign digit    = item.char_code[3:0];

  // year = hi*100 + lo
  assign leap = (year_lo == 7'd0) ? (year_hi[1:0] == 2'b00) : (year_lo[1:0] == 2'b00);
  assign days = (month == 7'd2 && leap) ? 5'd29 :
                (month <= MAX_MONTH)    ? MONTH_LEN[month[3:0]] : 5'd0;

  assign range_ok = ((year_hi != 7'd0) || (year_lo != 7'd0)) &&
                    (month != 7'd0) && (month <= MAX_MONTH) &&
                    (hour <= MAX_HOUR) && (minute <= MAX_MINSEC) &&
                    (second <= MAX_MINSEC) &&
                    (day != 7'd0) && (day <= {2'b00, days});

  // the final position holds Z, so no field changes on a good last byte
  assign ok = (position == POS_LAST) && !mismatch && (item.char_code == CH_Z) && range_ok;

  always_comb begin
    position_next = position;
    mismatch_next = mismatch;
    year_hi_next  = year_hi;
    year_lo_next  = year_lo;
    month_next    = month;
    day_next      = day;
    hour_next     = hour;
    minute_next   = minute;
    second_next   = second;
    if (position >= POS_SAT) begin
      mismatch_next = 1'b1;
    end else begin
      position_next = position + 5'd1;
      if (sep != SEP_NONE) begin
        if (item.char_code != sep) begin
          mismatch_next = 1'b1;
        end
      end else if (!is_digit) begin
        mismatch_next = 1'b1;
      end else begin
        case (field_of(position))
          FLD_YEAR_HI: year_hi_next = acc10(year_hi, digit);
          FLD_YEAR_LO: year_lo_next = acc10(year_lo, digit);
          FLD_MONTH:   month_next   = acc10(month, digit);
          FLD_DAY:     day_next     = acc10(day, digit);
          FLD_HOUR:    hour_next    = acc10(hour, digit);
          FLD_MINUTE:  minute_next  = acc10(minute, digit);
          FLD_SECOND:  second_next  = acc10(second, digit);
          default:     mismatch_next = mismatch;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.is_last)) begin
      position <= 5'd0;
      mismatch <= 1'b0;
      year_hi  <= 7'd0;
      year_lo  <= 7'd0;
      month    <= 7'd0;
      day      <= 7'd0;
      hour     <= 7'd0;
      minute   <= 7'd0;
      second   <= 7'd0;
    end else if (step) begin
      position <= position_next;
      mismatch <= mismatch_next;
      year_hi  <= year_hi_next;
      year_lo  <= year_lo_next;
      month    <= month_next;
      day      <= day_next;
      hour     <= hour_next;
      minute   <= minute_next;
      second   <= second_next;
    end
  end

endmodule

/* sv/iso8601_utc_timestamp_checker.sv */
// ----------------------------------------------------------------------------
// iso8601_utc_timestamp_checker
// Validates YYYY-MM-DDTHH:MM:SSZ strings streamed one byte per request.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one ASCII byte per request in char_code,
// with is_last high on the final byte of a string.
// Output channel (out_valid/out_ready): one timestamp_ok request per string,
// issued only for the byte carrying is_last.
// Path: a final byte passes through two register stages, the input register
// and then the result register, before its result is visible.
// Throughput: one byte per cycle; non-final bytes always advance, and a final
// byte advances while the result register is free or being drained.
// Stall: while a result waits on out_ready, non-final bytes still flow; a
// further final byte waits in the input register and in_ready drops.
// Reset: synchronous rst empties both registers, clears the string state and
// holds in_ready low.
// ----------------------------------------------------------------------------
module iso8601_utc_timestamp_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       timestamp_ok
);
  import isots_pkg::*;

  logic  s1_valid;
  item_t s1_item;
  logic  advance;
  logic  core_ok;

  assign advance  = s1_valid && (!s1_item.is_last || !out_valid || out_ready);
  assign in_ready = !rst && (!s1_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.char_code <= char_code;
      s1_item.is_last   <= is_last;
    end
  end

  isots_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (s1_item),
    .ok   (core_ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_item.is_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_item.is_last) begin
      timestamp_ok <= core_ok;
    end
  end

endmodule

/* sv/isots_checker.sv */
// ----------------------------------------------------------------------------
// isots_checker
// Port-level assertions for the ISO 8601 UTC timestamp checker.
// ----------------------------------------------------------------------------
`include "iso8601_utc_timestamp_checker_assert.svh"

module isots_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] char_code,
  input logic       is_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic       timestamp_ok
);

  `ISOTS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ISOTS_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(timestamp_ok))
  `ISOTS_ASSERT_IMPL(a_result_from_last, clk, rst, $rose(out_valid),
                     $past(in_valid && in_ready && is_last, 2))
  `ISOTS_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid)
  `ISOTS_ASSERT_IMPL(a_reset_no_ready, clk, 1'b0, rst, !in_ready)

endmodule

bind iso8601_utc_timestamp_checker isots_checker u_isots_checker (.*);
